>>> rtl/sliding_window_or_assert.svh
// ----------------------------------------------------------------------------
// Sliding window OR - assertion macros
// Concurrent assertion helpers; they compile to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_OR_ASSERT_SVH
`define SLIDING_WINDOW_OR_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define SWOR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sliding_window_or: assertion failed");
// next-cycle implication
`define SWOR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sliding_window_or: assertion failed");
`else
`define SWOR_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define SWOR_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

>>> rtl/swor_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window OR - package
// Shared constants and control types for the sliding window OR block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package swor_pkg;

   // defaults for the top-level parameters
   localparam int unsigned DATA_WIDTH_DEF = 32;
   localparam int unsigned MAX_WINDOW_DEF = 1024;

   // fixed port widths
   localparam int unsigned SAMPLE_WIDTH = 32;
   localparam int unsigned OR_WIDTH     = 32;
   localparam int unsigned LEN_WIDTH    = 11;

   // control from the pipeline to the bit counter bank
   typedef struct packed {
      logic clear;   // window restart
      logic step;    // one beat retires: leave oldest, enter newest
      logic leave;   // the beat evicts a word
   } cnt_ctrl_type;

endpackage

>>> rtl/swor_bitcnt.sv
// ----------------------------------------------------------------------------
// Sliding window OR - bit counter bank
// One population counter per bit lane; the OR is the set of nonzero lanes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module swor_bitcnt #(
   parameter int unsigned DATA_WIDTH = 32,
   parameter int unsigned CNT_WIDTH  = 11
) (
   input  logic                      clock,
   input  logic                      reset,
   input  swor_pkg::cnt_ctrl_type    ctrl,
   input  logic [DATA_WIDTH-1:0]     enter_word,
   input  logic [DATA_WIDTH-1:0]     leave_word,
   output logic [DATA_WIDTH-1:0]     or_next
);
   import swor_pkg::*;

   logic [CNT_WIDTH-1:0] cnt_ff [DATA_WIDTH];
   logic [CNT_WIDTH-1:0] cnt_in [DATA_WIDTH];

   // per-lane next count: drop the leaving bit, add the entering one
   always_comb begin
      for (int b = 0; b < DATA_WIDTH; b++) begin
         cnt_in[b] = cnt_ff[b];
         if (ctrl.leave && leave_word[b] && (cnt_ff[b] != '0)) begin
            cnt_in[b] = cnt_in[b] - CNT_WIDTH'(1);
         end
         if (enter_word[b]) begin
            cnt_in[b] = cnt_in[b] + CNT_WIDTH'(1);
         end
         or_next[b] = (cnt_in[b] != '0);
      end
   end

   // counter registers
   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         for (int b = 0; b < DATA_WIDTH; b++) begin
            cnt_ff[b] <= '0;
         end
      end else if (ctrl.step) begin
         for (int b = 0; b < DATA_WIDTH; b++) begin
            cnt_ff[b] <= cnt_in[b];
         end
      end
   end

endmodule

>>> rtl/sliding_window_or.sv
// ----------------------------------------------------------------------------
// Sliding window OR - top level
// Bitwise OR over the most recent window_len data words.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one sample per beat (valid/stall). rsp_* : one result per sample,
//   window_or plus window_full, in input order (valid/stall).
//   csr_*  : writes window_len (valid/ready); 0 acts as 1, values above
//   MAX_WINDOW saturate. A write restarts warm-up. Write only while idle.
// Timing:
//   A sample is taken into the middle stage while its evicted ring word is
//   read from the ring memory on the same edge; when the middle stage
//   retires, the counter bank updates into the output register. One beat
//   per cycle while rsp_stall is low. A new sample is taken while the
//   previous result still waits at the output. Rate is set by the ring
//   read/write pair, with the write of one beat forwarded to the read of
//   the next when they hit the same slot.
// Reset: counters, fill level and ring pointer clear, window_len becomes 1.
//   The ring memory is not cleared; a word is only evicted after it is written.
// Stall: with rsp_stall high the result holds; one more beat is absorbed in
//   the middle stage, after which req_stall rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sliding_window_or_assert.svh"

module sliding_window_or #(
   parameter int unsigned DATA_WIDTH = swor_pkg::DATA_WIDTH_DEF,
   parameter int unsigned MAX_WINDOW = swor_pkg::MAX_WINDOW_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // sample input
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [swor_pkg::SAMPLE_WIDTH-1:0] req_sample,
   // result output
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [swor_pkg::OR_WIDTH-1:0]     rsp_window_or,
   output logic                              rsp_window_full,
   // window length register
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [swor_pkg::LEN_WIDTH-1:0]    csr_window_len
);
   import swor_pkg::*;

   localparam int unsigned CW = $clog2(MAX_WINDOW + 1);
   localparam int unsigned AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

   // window state
   logic [CW-1:0]         eff_ff, eff_in;
   logic [CW-1:0]         fill_ff;
   logic [AW-1:0]         oldest_ff;

   // middle stage
   logic                  b_valid_ff;
   logic [DATA_WIDTH-1:0] b_sample_ff;
   logic [AW-1:0]         b_slot_ff;
   logic                  b_evict_ff;
   logic                  b_full_ff;
   logic                  b_fwd_ff;
   logic [DATA_WIDTH-1:0] b_fwd_data_ff;

   // ring memory
   logic [DATA_WIDTH-1:0] ring_mem [MAX_WINDOW];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // output register
   logic                  rsp_valid_ff;
   logic [OR_WIDTH-1:0]   rsp_or_ff;
   logic                  rsp_full_ff;

   logic                  req_accept, csr_write, b_go, b_fire;
   logic                  is_full, full_after, oldest_wrap;
   logic [AW-1:0]         acc_slot;
   logic [CW-1:0]         oldest_ext, oldest_inc;
   logic [DATA_WIDTH-1:0] leave_word, or_next;
   cnt_ctrl_type          cnt_ctrl;

   // handshakes
   assign b_go       = ~rsp_valid_ff | ~rsp_stall;
   assign b_fire     = b_valid_ff & b_go;
   assign req_stall  = b_valid_ff & ~b_go;
   assign req_accept = req_valid & ~req_stall;
   assign csr_ready  = ~b_valid_ff;
   assign csr_write  = csr_valid & csr_ready;

   // effective window length from the written value
   always_comb begin
      if (csr_window_len == '0) begin
         eff_in = CW'(1);
      end else if (32'(csr_window_len) > MAX_WINDOW) begin
         eff_in = CW'(MAX_WINDOW);
      end else begin
         eff_in = CW'(csr_window_len);
      end
   end

   // slot selection for the accepted beat
   assign is_full     = (fill_ff == eff_ff);
   assign acc_slot    = is_full ? oldest_ff : fill_ff[AW-1:0];
   assign oldest_ext  = CW'(oldest_ff);
   assign oldest_inc  = oldest_ext + CW'(1);
   assign oldest_wrap = (oldest_inc == eff_ff);
   assign full_after  = is_full | ((fill_ff + CW'(1)) == eff_ff);

   // window control state
   always_ff @(posedge clock) begin
      if (reset) begin
         eff_ff    <= CW'(1);
         fill_ff   <= '0;
         oldest_ff <= '0;
      end else if (csr_write) begin
         eff_ff    <= eff_in;
         fill_ff   <= '0;
         oldest_ff <= '0;
      end else if (req_accept) begin
         if (is_full) begin
            oldest_ff <= oldest_wrap ? '0 : oldest_inc[AW-1:0];
         end else begin
            fill_ff   <= fill_ff + CW'(1);
         end
      end
   end

   // middle stage valid
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (req_accept) begin
         b_valid_ff <= 1'b1;
      end else if (b_fire) begin
         b_valid_ff <= 1'b0;
      end
   end

   // middle stage payload; forward when the retiring beat writes our slot
   always_ff @(posedge clock) begin
      if (req_accept) begin
         b_sample_ff   <= DATA_WIDTH'(req_sample);
         b_slot_ff     <= acc_slot;
         b_evict_ff    <= is_full;
         b_full_ff     <= full_after;
         b_fwd_ff      <= b_fire && (b_slot_ff == acc_slot);
         b_fwd_data_ff <= b_sample_ff;
      end
   end

   // ring memory: write on retire, read the accepted beat's slot on accept
   always_ff @(posedge clock) begin
      if (b_fire) begin
         ring_mem[b_slot_ff] <= b_sample_ff;
      end
      if (req_accept) begin
         rd_data_ff <= ring_mem[acc_slot];
      end
   end

   assign leave_word = b_fwd_ff ? b_fwd_data_ff : rd_data_ff;

   // counter bank
   always_comb begin
      cnt_ctrl.clear = csr_write;
      cnt_ctrl.step  = b_fire;
      cnt_ctrl.leave = b_evict_ff;
   end

   swor_bitcnt #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_WIDTH  (CW)
   ) u_bitcnt (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (cnt_ctrl),
      .enter_word (b_sample_ff),
      .leave_word (leave_word),
      .or_next    (or_next)
   );

   // output register control
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (b_go) begin
         rsp_valid_ff <= b_valid_ff;
      end
   end

   // output register payload
   always_ff @(posedge clock) begin
      if (b_fire) begin
         rsp_or_ff   <= OR_WIDTH'(or_next);
         rsp_full_ff <= b_full_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_window_or   = rsp_or_ff;
   assign rsp_window_full = rsp_full_ff;

   // checks
   `SWOR_ASSERT_NEXT(a_accept_fills_stage, clock, reset, req_accept, b_valid_ff)
   `SWOR_ASSERT_NOW(a_fill_bounded, clock, reset, 1'b1, fill_ff <= eff_ff)
   `SWOR_ASSERT_NOW(a_oldest_in_window, clock, reset, 1'b1, oldest_ext < eff_ff)
   `SWOR_ASSERT_NEXT(a_full_evicts, clock, reset, req_accept && is_full, b_evict_ff && b_full_ff)

endmodule
